// ===== rtl/core/gmc_pkg.sv =====
// Shared widths, types and codes for the gated Mahalanobis cost block.
package gmc_pkg;

    localparam int unsigned FRAC_BITS_DEF = 16;

    // Remainder, divisor and quotient widths of the long division.
    localparam int unsigned RW = 100;
    localparam int unsigned DW = 66;
    localparam int unsigned QW = 34;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_COV_XX = 3'd0;
    localparam logic [2:0] REG_COV_XY = 3'd1;
    localparam logic [2:0] REG_COV_YX = 3'd2;
    localparam logic [2:0] REG_COV_YY = 3'd3;
    localparam logic [2:0] REG_GATE   = 3'd4;

    // Result kinds.
    typedef enum logic [1:0] {
        OUT_ACCEPT   = 2'd0,
        OUT_GATED    = 2'd1,
        OUT_SINGULAR = 2'd2
    } outcome_t;

    // One item inside the divider.
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [DW-1:0] den;
        logic [QW-1:0] quo;
        logic          neg;
        logic          ovf;
        logic          sing;
    } div_item_t;

endpackage

// ===== rtl/core/gated_mahalanobis_cost_2d_top.sv =====
// Top level of the gated 2D Mahalanobis association cost block.
//
// Input channel s_axis carries one track/object pair per item: predicted
// position, 2x2 prediction covariance and measured position. Output channel
// m_axis returns one item per input: the cost in tdata and the outcome kind
// (accepted, outside gate, singular covariance) in tuser.
// The configuration port writes the model covariance and the gate; writes take
// effect at the clock edge. The user must write only while the block is idle;
// the block itself does not enforce this. The pipeline has 7 front stages
// (sums, products, determinant, form, magnitudes), 34 single-bit long-division
// stages and one output register; it takes one item per cycle unless the receiver stalls.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and s_axis_tready drops, so nothing is
// lost or repeated. Reset empties the pipeline, clears the model covariance
// to zero and sets the gate to 9.0.
module gated_mahalanobis_cost_2d_top
#(
    parameter int unsigned FRAC_BITS = gmc_pkg::FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // pred_x, pred_y, pcov_xx, pcov_xy, pcov_yx, pcov_yy, obj_x, obj_y (32 bits each)
    input  logic [255:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // cost_value (32 bits)
    output logic [31:0]  m_axis_tdata,
    // outcome (2 bits)
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int unsigned NSTEP = gmc_pkg::QW;

    logic signed [31:0] cov_xx_reg, cov_xy_reg, cov_yx_reg, cov_yy_reg;
    logic [30:0]        gate_reg;

    logic               en;
    logic               front_valid;
    gmc_pkg::div_item_t front_item;
    logic               step_valid [NSTEP+1];
    gmc_pkg::div_item_t step_item  [NSTEP+1];
    logic signed [31:0] cost_value;
    gmc_pkg::outcome_t  outcome;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cov_xx_reg <= '0;
            cov_xy_reg <= '0;
            cov_yx_reg <= '0;
            cov_yy_reg <= '0;
            gate_reg   <= 31'(9) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gmc_pkg::REG_COV_XX: cov_xx_reg <= cfg_data;
                gmc_pkg::REG_COV_XY: cov_xy_reg <= cfg_data;
                gmc_pkg::REG_COV_YX: cov_yx_reg <= cfg_data;
                gmc_pkg::REG_COV_YY: cov_yy_reg <= cfg_data;
                gmc_pkg::REG_GATE:   gate_reg   <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output slot is free or being taken.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    gmc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s_axis_tvalid),
        .pred_x       (s_axis_tdata[31:0]),
        .pred_y       (s_axis_tdata[63:32]),
        .pcov_xx      (s_axis_tdata[95:64]),
        .pcov_xy      (s_axis_tdata[127:96]),
        .pcov_yx      (s_axis_tdata[159:128]),
        .pcov_yy      (s_axis_tdata[191:160]),
        .obj_x        (s_axis_tdata[223:192]),
        .obj_y        (s_axis_tdata[255:224]),
        .model_cov_xx (cov_xx_reg),
        .model_cov_xy (cov_xy_reg),
        .model_cov_yx (cov_yx_reg),
        .model_cov_yy (cov_yy_reg),
        .out_valid    (front_valid),
        .out_item     (front_item)
    );

    assign step_valid[0] = front_valid;
    assign step_item[0]  = front_item;

    // Quotient bits from the most significant down.
    for (genvar i = 0; i < NSTEP; i++)
    begin : g_div
        gmc_div_stage
        #(
            .SHIFT (NSTEP - 1 - i)
        )
        u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (step_valid[i]),
            .in_item   (step_item[i]),
            .out_valid (step_valid[i+1]),
            .out_item  (step_item[i+1])
        );
    end

    gmc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (step_valid[NSTEP]),
        .in_item    (step_item[NSTEP]),
        .gate_limit (gate_reg),
        .out_valid  (m_axis_tvalid),
        .cost_value (cost_value),
        .outcome    (outcome)
    );

    assign m_axis_tdata = cost_value;
    assign m_axis_tuser = outcome;

`ifndef SYNTHESIS
    // A gated or singular result carries a zero cost.
    a_zero_cost: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != gmc_pkg::OUT_ACCEPT) |-> m_axis_tdata == '0)
        else $error("nonzero cost on a rejected item");

    // An unused outcome code never leaves the block.
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("invalid outcome code");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");
`endif

endmodule

// ===== rtl/core/gmc_front.sv =====
// Front pipeline: sums, offsets, determinant, quadratic form and divider setup.
module gmc_front
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [31:0]      pred_x,
    input  logic signed [31:0]      pred_y,
    input  logic signed [31:0]      pcov_xx,
    input  logic signed [31:0]      pcov_xy,
    input  logic signed [31:0]      pcov_yx,
    input  logic signed [31:0]      pcov_yy,
    input  logic signed [31:0]      obj_x,
    input  logic signed [31:0]      obj_y,
    input  logic signed [31:0]      model_cov_xx,
    input  logic signed [31:0]      model_cov_xy,
    input  logic signed [31:0]      model_cov_yx,
    input  logic signed [31:0]      model_cov_yy,
    output logic                    out_valid,
    output gmc_pkg::div_item_t      out_item
);

    logic [6:0] v_reg;

    // Stage 1: covariance sums and offsets.
    logic signed [32:0] a1_reg, b1_reg, c1_reg, d1_reg, dx1_reg, dy1_reg;
    logic signed [33:0] s1_reg;
    // Stage 2: first products.
    logic signed [65:0] ad2_reg, bc2_reg, xx2_reg, xy2_reg, yy2_reg;
    logic signed [32:0] a2_reg, d2_reg;
    logic signed [33:0] s2_reg;
    // Stage 3: determinant and partial products of the form.
    logic signed [66:0] det3_reg;
    logic signed [66:0] p1l3_reg, p3l3_reg, p2h3_reg;
    logic signed [65:0] p1h3_reg, p3h3_reg;
    logic signed [67:0] p2l3_reg;
    // Stage 4: form terms, divisor magnitude.
    logic signed [99:0] t14_reg, t24_reg, t34_reg;
    logic [65:0]        den4_reg;
    logic               dneg4_reg, sing4_reg;
    // Stage 5: quadratic form.
    logic signed [99:0] form5_reg;
    logic [65:0]        den5_reg;
    logic               dneg5_reg, sing5_reg;
    // Stage 6: form magnitude.
    logic [99:0]        num6_reg;
    logic [65:0]        den6_reg;
    logic               neg6_reg, sing6_reg;
    // Stage 7: divider entry.
    gmc_pkg::div_item_t item7_reg;

    logic [65:0]        det_abs_next;
    logic [99:0]        form_abs_next;
    logic [99:0]        den_top_next;

    always_comb
    begin
        det_abs_next  = det3_reg[66] ? 66'(-det3_reg) : det3_reg[65:0];
        form_abs_next = form5_reg[99] ? 100'(-form5_reg) : form5_reg;
        den_top_next  = {den6_reg, 34'b0};
    end

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= 33'(pcov_xx) + 33'(model_cov_xx);
            b1_reg  <= 33'(pcov_xy) + 33'(model_cov_xy);
            c1_reg  <= 33'(pcov_yx) + 33'(model_cov_yx);
            d1_reg  <= 33'(pcov_yy) + 33'(model_cov_yy);
            s1_reg  <= 34'(pcov_xy) + 34'(model_cov_xy) + 34'(pcov_yx) + 34'(model_cov_yx);
            dx1_reg <= 33'(obj_x) - 33'(pred_x);
            dy1_reg <= 33'(obj_y) - 33'(pred_y);

            ad2_reg <= a1_reg * d1_reg;
            bc2_reg <= b1_reg * c1_reg;
            xx2_reg <= dx1_reg * dx1_reg;
            xy2_reg <= dx1_reg * dy1_reg;
            yy2_reg <= dy1_reg * dy1_reg;
            a2_reg  <= a1_reg;
            d2_reg  <= d1_reg;
            s2_reg  <= s1_reg;

            // Each 66-bit square or cross term is split into a low and a high half.
            det3_reg <= 67'(ad2_reg) - 67'(bc2_reg);
            p1l3_reg <= d2_reg * $signed({1'b0, xx2_reg[32:0]});
            p1h3_reg <= d2_reg * $signed(xx2_reg[65:33]);
            p2l3_reg <= s2_reg * $signed({1'b0, xy2_reg[32:0]});
            p2h3_reg <= s2_reg * $signed(xy2_reg[65:33]);
            p3l3_reg <= a2_reg * $signed({1'b0, yy2_reg[32:0]});
            p3h3_reg <= a2_reg * $signed(yy2_reg[65:33]);

            t14_reg   <= $signed({p1h3_reg[65], p1h3_reg, 33'b0}) + 100'(p1l3_reg);
            t24_reg   <= $signed({p2h3_reg, 33'b0}) + 100'(p2l3_reg);
            t34_reg   <= $signed({p3h3_reg[65], p3h3_reg, 33'b0}) + 100'(p3l3_reg);
            den4_reg  <= det_abs_next;
            dneg4_reg <= det3_reg[66];
            sing4_reg <= (det3_reg == '0);

            form5_reg <= t14_reg - t24_reg + t34_reg;
            den5_reg  <= den4_reg;
            dneg5_reg <= dneg4_reg;
            sing5_reg <= sing4_reg;

            num6_reg  <= form_abs_next;
            den6_reg  <= den5_reg;
            neg6_reg  <= form5_reg[99] ^ dneg5_reg;
            sing6_reg <= sing5_reg;

            // A quotient of 2^34 or more is settled here without dividing.
            item7_reg.rem  <= num6_reg;
            item7_reg.den  <= den6_reg;
            item7_reg.quo  <= '0;
            item7_reg.neg  <= neg6_reg;
            item7_reg.ovf  <= (num6_reg >= den_top_next);
            item7_reg.sing <= sing6_reg;
        end
    end

    assign out_valid = v_reg[6];
    assign out_item  = item7_reg;

endmodule

// ===== rtl/core/gmc_div_stage.sv =====
// One restoring step of the pipelined long division.
module gmc_div_stage
#(
    parameter int unsigned SHIFT = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  gmc_pkg::div_item_t      in_item,
    output logic                    out_valid,
    output gmc_pkg::div_item_t      out_item
);

    logic                          valid_reg;
    gmc_pkg::div_item_t            item_reg;
    gmc_pkg::div_item_t            item_next;
    logic [gmc_pkg::RW-1:0]        den_sh;
    logic                          fits;

    // Try to subtract the divisor at this bit weight.
    always_comb
    begin
        den_sh        = gmc_pkg::RW'(in_item.den) << SHIFT;
        fits          = (in_item.rem >= den_sh);
        item_next     = in_item;
        item_next.rem = fits ? in_item.rem - den_sh : in_item.rem;
        item_next.quo = {in_item.quo[gmc_pkg::QW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/core/gmc_back.sv =====
// Output stage: floor rounding, gate test, halving and saturation.
module gmc_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  gmc_pkg::div_item_t      in_item,
    input  logic [30:0]             gate_limit,
    output logic                    out_valid,
    output logic signed [31:0]      cost_value,
    output gmc_pkg::outcome_t       outcome
);

    logic                 valid_reg;
    logic signed [31:0]   cost_reg;
    gmc_pkg::outcome_t    outcome_reg;

    logic [35:0]          mag;
    logic signed [35:0]   q;
    logic signed [35:0]   half;
    logic signed [31:0]   cost_next;
    gmc_pkg::outcome_t    outcome_next;

    // Signed floor quotient, then the result selection.
    always_comb
    begin
        mag  = 36'(in_item.quo) + 36'(in_item.rem != '0);
        q    = in_item.neg ? $signed(-mag) : $signed({2'b0, in_item.quo});
        half = q >>> 1;
        cost_next    = '0;
        outcome_next = gmc_pkg::OUT_ACCEPT;
        if (in_item.sing)
        begin
            outcome_next = gmc_pkg::OUT_SINGULAR;
        end
        else if (in_item.ovf)
        begin
            if (in_item.neg)
            begin
                cost_next = 32'sh8000_0000;
            end
            else
            begin
                outcome_next = gmc_pkg::OUT_GATED;
            end
        end
        else if (q >= $signed({5'b0, gate_limit}))
        begin
            outcome_next = gmc_pkg::OUT_GATED;
        end
        else if (half < -36'sd2147483648)
        begin
            cost_next = 32'sh8000_0000;
        end
        else
        begin
            cost_next = half[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cost_reg    <= cost_next;
            outcome_reg <= outcome_next;
        end
    end

    assign out_valid  = valid_reg;
    assign cost_value = cost_reg;
    assign outcome    = outcome_reg;

endmodule

// ===== sim/gated_mahalanobis_cost_2d_top_test.sv =====
// Self-checking testbench for the gated 2D Mahalanobis association cost block.
module gated_mahalanobis_cost_2d_top_test;

    localparam int LATENCY    = 42;
    localparam int SETTLE     = LATENCY + 8;
    localparam int WATCHDOG   = 5000;
    localparam int LONG_HOLD  = 300;
    localparam int MAX_REPORT = 10;
    localparam int Q          = 1 << gmc_pkg::FRAC_BITS_DEF;

    // One track/object pair.
    typedef struct {
        logic signed [31:0] pred_x;
        logic signed [31:0] pred_y;
        logic signed [31:0] pcov_xx;
        logic signed [31:0] pcov_xy;
        logic signed [31:0] pcov_yx;
        logic signed [31:0] pcov_yy;
        logic signed [31:0] obj_x;
        logic signed [31:0] obj_y;
    } pair_t;

    // One scored pair.
    typedef struct {
        logic [31:0]       cost;
        gmc_pkg::outcome_t kind;
    } score_t;

    logic         clk;
    logic         rst_n;
    logic [255:0] s_axis_tdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    // Shadow copy of the configuration registers.
    logic signed [31:0] model_cov [4];
    logic [30:0]        gate_reg;

    score_t pending_scores[$];
    int     mismatches;
    int     idle_cycles;
    bit     sender_gaps;
    bit     receiver_stalls;
    bit     hold_request;

    gated_mahalanobis_cost_2d_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Exact scoring of one pair with the current configuration.
    function automatic score_t predict_score(pair_t p);
        logic signed [159:0] a, b, c, d, dx, dy;
        logic signed [159:0] det, form, quot, rem, half, gate_wide;
        score_t s;
        a  = 160'(p.pcov_xx) + 160'(model_cov[0]);
        b  = 160'(p.pcov_xy) + 160'(model_cov[1]);
        c  = 160'(p.pcov_yx) + 160'(model_cov[2]);
        d  = 160'(p.pcov_yy) + 160'(model_cov[3]);
        dx = 160'(p.obj_x) - 160'(p.pred_x);
        dy = 160'(p.obj_y) - 160'(p.pred_y);
        det = a * d - b * c;
        s.cost = '0;
        if (det == 0)
        begin
            s.kind = gmc_pkg::OUT_SINGULAR;
            return s;
        end
        form = d * dx * dx - (b + c) * dx * dy + a * dy * dy;
        quot = form / det;
        rem  = form % det;
        // Division truncates toward zero; move to floor when signs differ.
        if (rem != 0 && ((form < 0) != (det < 0)))
            quot = quot - 1;
        gate_wide = {129'b0, gate_reg};
        if (quot >= gate_wide)
        begin
            s.kind = gmc_pkg::OUT_GATED;
            return s;
        end
        half = quot >>> 1;
        if (half < -160'sd2147483648)
            half = -160'sd2147483648;
        else if (half > 160'sd2147483647)
            half = 160'sd2147483647;
        s.cost = half[31:0];
        s.kind = gmc_pkg::OUT_ACCEPT;
        return s;
    endfunction

    // Offer one item and record its score once the block takes it.
    task automatic send_pair(pair_t p);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {p.obj_y, p.obj_x, p.pcov_yy, p.pcov_yx,
                          p.pcov_xy, p.pcov_xx, p.pred_y, p.pred_x};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_scores.push_back(predict_score(p));
    endtask

    // Drop valid and wait until every score has come back, then let the pipe settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write one register; only called while the block is idle.
    task automatic write_reg(logic [2:0] index, logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            gmc_pkg::REG_COV_XX: model_cov[0] = value;
            gmc_pkg::REG_COV_XY: model_cov[1] = value;
            gmc_pkg::REG_COV_YX: model_cov[2] = value;
            gmc_pkg::REG_COV_YY: model_cov[3] = value;
            gmc_pkg::REG_GATE:   gate_reg     = value[30:0];
            default:    ;
        endcase
    endtask

    task automatic write_all(logic [31:0] xx, logic [31:0] xy, logic [31:0] yx,
                             logic [31:0] yy, logic [31:0] gate);
        write_reg(gmc_pkg::REG_COV_XX, xx);
        write_reg(gmc_pkg::REG_COV_XY, xy);
        write_reg(gmc_pkg::REG_COV_YX, yx);
        write_reg(gmc_pkg::REG_COV_YY, yy);
        write_reg(gmc_pkg::REG_GATE, gate);
    endtask

    function automatic pair_t random_pair();
        pair_t p;
        p.pred_x  = $urandom();
        p.pred_y  = $urandom();
        p.pcov_xx = $urandom();
        p.pcov_xy = $urandom();
        p.pcov_yx = $urandom();
        p.pcov_yy = $urandom();
        p.obj_x   = $urandom();
        p.obj_y   = $urandom();
        return p;
    endfunction

    // A plausible pair: positive definite covariance, object near the track.
    function automatic pair_t near_pair();
        pair_t p;
        int off;
        p.pred_x  = $urandom_range(0, 32'h3fff_ffff) - 32'h2000_0000;
        p.pred_y  = $urandom_range(0, 32'h3fff_ffff) - 32'h2000_0000;
        p.pcov_xx = $urandom_range(Q / 4, 16 * Q);
        p.pcov_yy = $urandom_range(Q / 4, 16 * Q);
        off       = $urandom_range(0, Q / 2) - Q / 4;
        p.pcov_xy = off;
        p.pcov_yx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, Q / 2) - Q / 4 : off;
        p.obj_x   = p.pred_x + $urandom_range(0, 8 * Q) - 4 * Q;
        p.obj_y   = p.pred_y + $urandom_range(0, 8 * Q) - 4 * Q;
        return p;
    endfunction

    function automatic pair_t make_pair(int px, int py, int cxx, int cxy, int cyx,
                                        int cyy, int ox, int oy);
        pair_t p;
        p.pred_x  = px;
        p.pred_y  = py;
        p.pcov_xx = cxx;
        p.pcov_xy = cxy;
        p.pcov_yx = cyx;
        p.pcov_yy = cyy;
        p.obj_x   = ox;
        p.obj_y   = oy;
        return p;
    endfunction

    // Directed pairs under the reset configuration.
    task automatic test_directed();
        int mn;
        int mx;
        mn = 32'h8000_0000;
        mx = 32'h7fff_ffff;
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(0, 0, Q, 0, 0, Q, Q, 0));
        send_pair(make_pair(0, 0, Q, 0, 0, Q, 0, 0));
        send_pair(make_pair(Q, Q, Q, 0, 0, Q, 4 * Q, 5 * Q));
        send_pair(make_pair(0, 0, Q, 0, 0, Q, 3 * Q, 0));
        send_pair(make_pair(0, 0, 2 * Q, Q, Q, Q / 2, Q, Q));
        send_pair(make_pair(0, 0, Q, 2 * Q, 2 * Q, Q, Q, 0));
        send_pair(make_pair(0, 0, -Q, 0, 0, Q, Q, 0));
        send_pair(make_pair(0, 0, -Q, 0, 0, -Q, Q, Q));
        send_pair(make_pair(0, 0, Q, Q, -Q, Q, 0, 2 * Q));
        send_pair(make_pair(0, 0, Q, Q, Q, Q, Q, -Q));
        send_pair(make_pair(mx, mx, mx, mx, mx, mx, mn, mn));
        send_pair(make_pair(mn, mn, mn, mn, mn, mn, mx, mx));
        send_pair(make_pair(mn, mx, mx, 0, 0, mx, mx, mn));
        send_pair(make_pair(0, 0, mx, mn, mx, mn, 1, -1));
        send_pair(make_pair(-1, -1, 1, 0, 0, 1, 0, 0));
        send_pair(make_pair(5, -7, 3, 1, 2, 1, 0, 0));
        send_pair(make_pair(0, 0, Q, 0, 0, Q, -Q, 2 * Q));
        drain();
    endtask

    // Register extremes and several settings, including index writes that are ignored.
    task automatic test_config_sweep();
        int k;
        write_all(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        for (k = 0; k < 40; k++)
            send_pair(($urandom_range(0, 1) == 0) ? random_pair() : near_pair());
        drain();
        write_all(0, 0, 0, 0, 0);
        for (k = 0; k < 40; k++)
            send_pair(($urandom_range(0, 1) == 0) ? random_pair() : near_pair());
        drain();
        // Tiny covariance, wide gate: negative costs saturate, positives are gated.
        write_all(0, 0, 0, 0, 32'h7fff_ffff);
        send_pair(make_pair(0, 0, 1, 0, 0, 1, 32'h7fff_ffff, 32'h7fff_ffff));
        send_pair(make_pair(0, 0, -1, 0, 0, 1, 32'h7fff_ffff, 0));
        send_pair(make_pair(0, 0, 1, 0, 0, -1, 32'h4000_0000, 1));
        for (k = 0; k < 40; k++)
            send_pair(($urandom_range(0, 1) == 0) ? random_pair() : near_pair());
        drain();
        write_reg(3'd5, $urandom());
        write_reg(3'd6, $urandom());
        write_reg(3'd7, $urandom());
        write_all(Q / 2, 0, 0, Q / 2, 9 * Q);
        for (k = 0; k < 40; k++)
            send_pair(near_pair());
        drain();
    endtask

    // Bulk random traffic over a few configurations.
    task automatic test_random();
        int phase;
        int k;
        for (phase = 0; phase < 4; phase++)
        begin
            write_all($urandom_range(0, 2 * Q), $urandom_range(0, Q / 2) - Q / 4,
                      $urandom_range(0, Q / 2) - Q / 4, $urandom_range(0, 2 * Q),
                      (phase == 3) ? $urandom() : $urandom_range(Q, 64 * Q));
            receiver_stalls = (phase != 1);
            sender_gaps     = (phase != 2);
            for (k = 0; k < 400; k++)
                send_pair(($urandom_range(0, 3) == 0) ? random_pair() : near_pair());
            drain();
        end
        receiver_stalls = 1'b1;
        sender_gaps     = 1'b1;
    endtask

    // Receiver holds off long enough for the pipeline to fill and stall input.
    task automatic test_backpressure();
        int k;
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        for (k = 0; k < 100; k++)
            send_pair(near_pair());
        sender_gaps = 1'b1;
        drain();
    endtask

    // Receiver side: random stalls per item and one long hold on request.
    initial
    begin
        int w;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            w = receiver_stalls ? $urandom_range(0, 7) : 0;
            if (w > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Compare every accepted result with the oldest predicted score.
    always @(posedge clk)
    begin
        score_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_scores.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORT)
                    $display("ERROR: unexpected result cost=%h outcome=%0d",
                             m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_scores.pop_front();
                if (m_axis_tdata !== want.cost || m_axis_tuser !== want.kind)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORT)
                        $display("ERROR: cost %h outcome %0d, expected cost %h outcome %0d",
                                 m_axis_tdata, m_axis_tuser, want.cost, want.kind);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        mismatches      = 0;
        idle_cycles     = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        hold_request    = 1'b0;
        model_cov[0]    = '0;
        model_cov[1]    = '0;
        model_cov[2]    = '0;
        model_cov[3]    = '0;
        gate_reg        = 31'(9 * Q);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();

        if (pending_scores.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gmc_pkg.sv
rtl/core/gmc_front.sv
rtl/core/gmc_div_stage.sv
rtl/core/gmc_back.sv
rtl/core/gated_mahalanobis_cost_2d_top.sv
sim/gated_mahalanobis_cost_2d_top_test.sv
